/* rtl/core/rdtm_pkg.sv */
// Package: shared types, constants and register indexes for the ROI dwell monitor.
`timescale 1ns / 1ps
package rdtm_pkg;
	localparam int TRACKS_DEF = 64;

	localparam logic [2:0] REG_ROI_LEFT   = 3'd0;
	localparam logic [2:0] REG_ROI_TOP    = 3'd1;
	localparam logic [2:0] REG_ROI_WIDTH  = 3'd2;
	localparam logic [2:0] REG_ROI_HEIGHT = 3'd3;
	localparam logic [2:0] REG_DWELL      = 3'd4;

	localparam logic [1:0] ST_OUTSIDE = 2'd0;
	localparam logic [1:0] ST_INSIDE  = 2'd1;
	localparam logic [1:0] ST_ALERT   = 2'd2;

	// monitored detector classes
	localparam logic [7:0] CLASS_MON_A = 8'd0;
	localparam logic [7:0] CLASS_MON_B = 8'd2;

	typedef struct packed {
		logic        first_of_frame;
		logic        monitored;
		logic        in_roi;
		logic [31:0] obj_id;
		logic [31:0] now_ms;
	} job_t;

	typedef struct packed {
		logic        in_roi;
		logic [1:0]  track_state;
		logic        alert_raised;
		logic        track_added;
		logic        table_full;
		logic [31:0] dwell_ms;
		logic        frame_has_inside;
		logic        frame_has_alert;
		logic [31:0] detected_count;
		logic [31:0] alert_count;
	} result_t;

	// entry record: alerted, last dwell, start, state, id
	localparam int ENTRY_W = 1 + 32 + 32 + 2 + 32;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_WAIT,
		BK_UPDATE,
		BK_WRITE,
		BK_EMIT
	} bk_state_t;
endpackage

/* rtl/core/roi_dwell_time_monitor_top.sv */
// Top level of the ROI dwell-time monitor.
// channel | handshake        | payload
// input   | push / full      | first_of_frame, obj_id, obj_class, box_*, now_ms
// result  | pop / empty      | in_roi .. alert_count
// config  | cfg_valid/ready  | cfg_index, cfg_data
// For a monitored object the back end scans the track table one entry per cycle
// through its single RAM port, then updates and writes.
// Unmonitored objects are popped from the job queue in the idle state, without a table scan.
// The back end holds a new object while a result waits in the output register.
// Reset clears the fill count, counters and flags; the table RAM needs no clearing.
`timescale 1ns / 1ps
module roi_dwell_time_monitor_top #(
	parameter int TRACKS = rdtm_pkg::TRACKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        first_of_frame,
	input  logic [31:0] obj_id,
	input  logic [7:0]  obj_class,
	input  logic [11:0] box_left,
	input  logic [11:0] box_top,
	input  logic [11:0] box_width,
	input  logic [11:0] box_height,
	input  logic [31:0] now_ms,
	output logic        empty,
	input  logic        pop,
	output logic        in_roi,
	output logic [1:0]  track_state,
	output logic        alert_raised,
	output logic        track_added,
	output logic        table_full,
	output logic [31:0] dwell_ms,
	output logic        frame_has_inside,
	output logic        frame_has_alert,
	output logic [31:0] detected_count,
	output logic [31:0] alert_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [11:0] roi_left_q, roi_top_q, roi_width_q, roi_height_q;
	logic [31:0] dwell_limit_q;
	rdtm_pkg::job_t job_in, job_out;
	rdtm_pkg::result_t res;
	logic q_empty, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_left_q <= 12'd576;
			roi_top_q <= 12'd324;
			roi_width_q <= 12'd768;
			roi_height_q <= 12'd432;
			dwell_limit_q <= 32'd5000;
		end else if (cfg_valid) begin
			case (cfg_index)
				rdtm_pkg::REG_ROI_LEFT:   roi_left_q <= cfg_data[11:0];
				rdtm_pkg::REG_ROI_TOP:    roi_top_q <= cfg_data[11:0];
				rdtm_pkg::REG_ROI_WIDTH:  roi_width_q <= cfg_data[11:0];
				rdtm_pkg::REG_ROI_HEIGHT: roi_height_q <= cfg_data[11:0];
				rdtm_pkg::REG_DWELL:      dwell_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rdtm_front u_front (
		.first_of_frame(first_of_frame), .obj_id(obj_id), .obj_class(obj_class),
		.box_left(box_left), .box_top(box_top), .box_width(box_width),
		.box_height(box_height), .now_ms(now_ms),
		.roi_left_q(roi_left_q), .roi_top_q(roi_top_q),
		.roi_width_q(roi_width_q), .roi_height_q(roi_height_q), .job(job_in)
	);

	rdtm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(push), .wdata(job_in), .full(full),
		.rd(q_pop), .empty(q_empty), .rdata(job_out)
	);

	rdtm_back #(.TRACKS(TRACKS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_empty(q_empty), .job(job_out),
		.job_pop(q_pop), .dwell_limit_q(dwell_limit_q), .empty(empty), .pop(pop),
		.res(res)
	);

	assign in_roi = res.in_roi;
	assign track_state = res.track_state;
	assign alert_raised = res.alert_raised;
	assign track_added = res.track_added;
	assign table_full = res.table_full;
	assign dwell_ms = res.dwell_ms;
	assign frame_has_inside = res.frame_has_inside;
	assign frame_has_alert = res.frame_has_alert;
	assign detected_count = res.detected_count;
	assign alert_count = res.alert_count;
endmodule

/* rtl/core/rdtm_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rdtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/core/rdtm_front.sv */
// Front end: class filter and ROI test of the box centre, builds a job beat.
`timescale 1ns / 1ps
module rdtm_front (
	input  logic        first_of_frame,
	input  logic [31:0] obj_id,
	input  logic [7:0]  obj_class,
	input  logic [11:0] box_left,
	input  logic [11:0] box_top,
	input  logic [11:0] box_width,
	input  logic [11:0] box_height,
	input  logic [31:0] now_ms,
	input  logic [11:0] roi_left_q,
	input  logic [11:0] roi_top_q,
	input  logic [11:0] roi_width_q,
	input  logic [11:0] roi_height_q,
	output rdtm_pkg::job_t job
);
	logic [14:0] cx2, cy2, x0, x1, y0, y1;

	always_comb begin
		cx2 = {2'b0, box_left, 1'b0} + {3'b0, box_width};
		cy2 = {2'b0, box_top, 1'b0} + {3'b0, box_height};
		x0  = {2'b0, roi_left_q, 1'b0};
		y0  = {2'b0, roi_top_q, 1'b0};
		x1  = {1'b0, ({1'b0, roi_left_q} + {1'b0, roi_width_q}), 1'b0};
		y1  = {1'b0, ({1'b0, roi_top_q} + {1'b0, roi_height_q}), 1'b0};
		job.first_of_frame = first_of_frame;
		job.monitored = (obj_class == rdtm_pkg::CLASS_MON_A) ||
			(obj_class == rdtm_pkg::CLASS_MON_B);
		job.in_roi = (cx2 >= x0) && (cx2 <= x1) && (cy2 >= y0) && (cy2 <= y1);
		job.obj_id = obj_id;
		job.now_ms = now_ms;
	end
endmodule

/* rtl/core/rdtm_queue.sv */
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module rdtm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  rdtm_pkg::job_t wdata,
	output logic           full,
	input  logic           rd,
	output logic           empty,
	output rdtm_pkg::job_t rdata
);
	rdtm_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= !wp_q;
			if (rd && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr && !full} - {1'b0, rd && !empty};
		end
	end
endmodule

/* rtl/core/rdtm_back.sv */
// Back end: table search, track state update, counters and result register.
`timescale 1ns / 1ps
module rdtm_back #(
	parameter int TRACKS = rdtm_pkg::TRACKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_empty,
	input  rdtm_pkg::job_t job,
	output logic           job_pop,
	input  logic [31:0]    dwell_limit_q,
	output logic           empty,
	input  logic           pop,
	output rdtm_pkg::result_t res
);
	localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int CW = $clog2(TRACKS + 1);
	localparam int RD = (TRACKS > 1) ? TRACKS : 2;

	rdtm_pkg::bk_state_t state_q, state_d;
	// entries fill in order and are never freed: entry i is valid when i < fill_q
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] slot_q, free_q, addr;
	logic hit_q, free_ok_q;
	logic we;
	logic [rdtm_pkg::ENTRY_W-1:0] wdata, rdata;
	logic [31:0] tracks_q, alerts_q;
	logic fin_q, fal_q, res_v_q;
	rdtm_pkg::result_t res_q;
	logic [31:0] id_r;
	logic [1:0] st_r;
	logic [31:0] start_r, last_r;
	logic alerted_r;
	logic [31:0] e_id, e_start, e_last, diff;
	logic [1:0] e_st, st_n;
	logic e_al, raised, added;
	logic [31:0] dwell;
	logic fin_n, fal_n;

	rdtm_ram #(.WIDTH(rdtm_pkg::ENTRY_W), .DEPTH(RD)) u_tab (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign {alerted_r, last_r, start_r, st_r, id_r} = rdata;
	assign empty = !res_v_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdtm_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		addr = idx_q[AW-1:0];
		we = 1'b0;
		case (state_q)
			rdtm_pkg::BK_IDLE: begin
				if (!job_empty && !res_v_q) begin
					if (job.monitored) begin
						state_d = rdtm_pkg::BK_SCAN;
					end else begin
						job_pop = 1'b1;
					end
				end
			end
			rdtm_pkg::BK_SCAN: begin
				if (idx_q == CW'(TRACKS)) state_d = rdtm_pkg::BK_WAIT;
			end
			rdtm_pkg::BK_WAIT: begin
				addr = slot_q;
				state_d = rdtm_pkg::BK_UPDATE;
			end
			rdtm_pkg::BK_UPDATE: begin
				addr = slot_q;
				state_d = rdtm_pkg::BK_WRITE;
			end
			rdtm_pkg::BK_WRITE: begin
				addr = slot_q;
				we = hit_q || free_ok_q;
				job_pop = 1'b1;
				state_d = rdtm_pkg::BK_EMIT;
			end
			rdtm_pkg::BK_EMIT: begin
				state_d = rdtm_pkg::BK_IDLE;
			end
			default: state_d = rdtm_pkg::BK_IDLE;
		endcase
	end

	// entry as seen at update: a fresh entry when added
	always_comb begin
		added = !hit_q && free_ok_q;
		e_id = job.obj_id;
		e_st = added ? rdtm_pkg::ST_OUTSIDE : st_r;
		e_start = added ? 32'd0 : start_r;
		e_last = added ? 32'd0 : last_r;
		e_al = added ? 1'b0 : alerted_r;
		diff = job.now_ms - e_start;
		st_n = e_st;
		raised = 1'b0;
		fin_n = (job.first_of_frame ? 1'b0 : fin_q) | job.in_roi;
		fal_n = job.first_of_frame ? 1'b0 : fal_q;
		dwell = 32'd0;
		if (!hit_q && !free_ok_q) begin
			st_n = job.in_roi ? rdtm_pkg::ST_INSIDE : rdtm_pkg::ST_OUTSIDE;
		end else begin
			if (job.in_roi) begin
				if (e_st == rdtm_pkg::ST_OUTSIDE) begin
					st_n = rdtm_pkg::ST_INSIDE;
					e_start = job.now_ms;
				end else if (e_st == rdtm_pkg::ST_INSIDE && diff >= dwell_limit_q) begin
					st_n = rdtm_pkg::ST_ALERT;
					e_al = 1'b1;
					raised = 1'b1;
				end
				if (st_n == rdtm_pkg::ST_ALERT) fal_n = 1'b1;
			end else if (e_st != rdtm_pkg::ST_OUTSIDE) begin
				e_last = diff;
				st_n = rdtm_pkg::ST_OUTSIDE;
			end
			dwell = (st_n != rdtm_pkg::ST_OUTSIDE) ? job.now_ms - e_start : e_last;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rdtm_pkg::BK_UPDATE) begin
			wdata <= {e_al, e_last, e_start, st_n, e_id};
			res_q.in_roi <= job.in_roi;
			res_q.track_state <= st_n;
			res_q.alert_raised <= raised;
			res_q.track_added <= added;
			res_q.table_full <= !hit_q && !free_ok_q;
			res_q.dwell_ms <= dwell;
			res_q.frame_has_inside <= fin_n;
			res_q.frame_has_alert <= fal_n;
			res_q.detected_count <= (added && tracks_q != '1) ? tracks_q + 32'd1 : tracks_q;
			res_q.alert_count <= (raised && alerts_q != '1) ? alerts_q + 32'd1 : alerts_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			free_q <= '0;
			hit_q <= 1'b0;
			free_ok_q <= 1'b0;
			tracks_q <= '0;
			alerts_q <= '0;
			fin_q <= 1'b0;
			fal_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (pop && res_v_q) res_v_q <= 1'b0;
			if (job_pop && !job.monitored && job.first_of_frame) begin
				fin_q <= 1'b0;
				fal_q <= 1'b0;
			end
			case (state_q)
				rdtm_pkg::BK_IDLE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					free_ok_q <= 1'b0;
				end
				rdtm_pkg::BK_SCAN: begin
					// rdata holds entry idx_q-1
					if (idx_q != '0) begin
						if ((idx_q - CW'(1)) < fill_q) begin
							if (!hit_q && id_r == job.obj_id) begin
								hit_q <= 1'b1;
								slot_q <= AW'(idx_q - CW'(1));
							end
						end else if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= AW'(idx_q - CW'(1));
						end
					end
					if (idx_q != CW'(TRACKS)) idx_q <= idx_q + CW'(1);
				end
				rdtm_pkg::BK_WAIT: begin
					if (!hit_q) slot_q <= free_q;
				end
				rdtm_pkg::BK_UPDATE: begin
					fin_q <= fin_n;
					fal_q <= fal_n;
					if (added) begin
						fill_q <= fill_q + CW'(1);
						if (tracks_q != '1) tracks_q <= tracks_q + 32'd1;
					end
					if (raised && alerts_q != '1) alerts_q <= alerts_q + 32'd1;
				end
				rdtm_pkg::BK_WRITE: res_v_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

/* rtl/core/rdtm_checker.sv */
// Port-level assertions for the ROI dwell-time monitor, bound to the top.
`timescale 1ns / 1ps
module rdtm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  track_state,
	input logic        alert_raised,
	input logic        track_added,
	input logic        table_full,
	input logic [31:0] dwell_ms,
	input logic [31:0] alert_count
);
	a_raise_state: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && alert_raised |-> track_state == rdtm_pkg::ST_ALERT)
		else $error("raised alert without alert state");
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(table_full && (track_added || alert_raised)))
		else $error("table full with stored effect");
	a_full_dwell: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && table_full |-> dwell_ms == 32'd0)
		else $error("table full with nonzero dwell");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(alert_count))
		else $error("stalled result changed");
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && alert_raised |-> alert_count != 32'd0)
		else $error("alert count not advanced");
endmodule

bind roi_dwell_time_monitor_top rdtm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.track_state(track_state), .alert_raised(alert_raised), .track_added(track_added),
	.table_full(table_full), .dwell_ms(dwell_ms), .alert_count(alert_count)
);
